@@ rtl/core/hpd_pkg.sv @@
package hpd_pkg;

	// Table and field geometry.
	localparam int SYMBOL_COUNT = 256;
	localparam int MAX_CODE_LEN = 16;
	localparam int SYM_W = 8;
	localparam int CODE_W = 16;
	localparam int LEN_W = 5;

	// Each cell of the chain holds a fixed slice of the table.
	localparam int CELL_ENTRIES = 16;
	localparam int ENTRY_W = $clog2(CELL_ENTRIES);
	localparam int CELL_ID_W = SYM_W - ENTRY_W;
	localparam int CELL_COUNT = (SYMBOL_COUNT + CELL_ENTRIES - 1) / CELL_ENTRIES;

	// Prefix bit counter and the width used to compare it against lengths.
	localparam int CNT_W = $clog2(MAX_CODE_LEN + 1);
	localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

	// Item action codes.
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_DECODE = 1'b1;

	typedef struct packed {
		logic action;
		logic [SYM_W-1:0] symbol;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0] code_length;
		logic coded_bit;
	} in_item_t;

	typedef struct packed {
		logic [SYM_W-1:0] decoded_symbol;
		logic overflow;
	} out_item_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic write;
		logic [ENTRY_W-1:0] entry;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0] length;
		logic probe;
		logic [CODE_W-1:0] bits;
		logic [CODE_W-1:0] mask;
		logic [CNT_W-1:0] count;
	} cell_ctl_t;

	// Best match so far, passed from higher cells to lower cells.
	typedef struct packed {
		logic hit;
		logic [SYM_W-1:0] symbol;
	} link_t;

endpackage

@@ rtl/core/hpd_cell.sv @@
module hpd_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  hpd_pkg::cell_ctl_t        ctl,
	input  logic                      sel,
	input  logic [hpd_pkg::CELL_ID_W-1:0] cell_id,
	input  hpd_pkg::link_t            link_in,
	output hpd_pkg::link_t            link_out
);
	import hpd_pkg::*;

	logic [CODE_W-1:0] code_q [CELL_ENTRIES];
	logic [LEN_W-1:0] len_q [CELL_ENTRIES];
	logic hit_q;
	logic [ENTRY_W-1:0] idx_q;
	logic local_hit;
	logic [ENTRY_W-1:0] local_idx;

	// Code storage needs no reset: a code is only looked at once its length is set.
	always_ff @(posedge clk) begin
		if (ctl.write && sel) begin
			code_q[ctl.entry] <= ctl.code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CELL_ENTRIES; i++) begin
				len_q[i] <= '0;
			end
		end else if (ctl.write && sel) begin
			len_q[ctl.entry] <= ctl.length;
		end
	end

	// Compare every entry of the slice; the highest matching entry wins.
	always_comb begin
		local_hit = 1'b0;
		local_idx = '0;
		for (int i = 0; i < CELL_ENTRIES; i++) begin
			if ((CMP_W'(len_q[i]) == CMP_W'(ctl.count)) &&
			    (((code_q[i] ^ ctl.bits) & ctl.mask) == '0)) begin
				local_hit = 1'b1;
				local_idx = ENTRY_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.probe) begin
			hit_q <= local_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.probe) begin
			idx_q <= local_idx;
		end
	end

	// A match from a higher cell outranks this one.
	always_comb begin
		if (link_in.hit) begin
			link_out = link_in;
		end else begin
			link_out.hit = hit_q;
			link_out.symbol = {cell_id, idx_q};
		end
	end

endmodule

@@ rtl/core/huffman_prefix_decoder.sv @@
// Huffman prefix decoder.
// The item channel (item_valid, item_ready, item) carries two kinds of
// transfer. A write item loads the code and length of one symbol into the
// table and gives no result. A decode item appends one coded bit to the
// running prefix, first bit most significant. When a table entry of the
// same length and code matches the prefix, the symbol comes out on the
// result channel (result_valid, result_ready, result) and the prefix is
// cleared; the highest matching symbol wins. A prefix that reaches the
// maximum code length without a match gives a result with overflow set.
// In the transfer of a decode item every cell compares its slice of the
// table and registers its hit; once the output register is free, the best
// match ripples down the cell chain into it. No item is taken while a
// decode item waits for its match; writes go one per cycle otherwise.
// Reset clears all table lengths (no entries) and the prefix.
// If the receiver stalls, a waiting result sits in the output register and
// further items are still taken until a decode item needs that register.
module huffman_prefix_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  hpd_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_ready,
	output hpd_pkg::out_item_t result
);
	import hpd_pkg::*;

	logic [CODE_W-1:0] prefix_q;
	logic [CNT_W-1:0] count_q;
	logic pend_q;
	logic out_valid_q;
	out_item_t out_q;

	logic accept;
	logic decode_acc;
	logic write_acc;
	logic resolve;
	logic reached_max;
	logic [CODE_W-1:0] next_bits;
	logic [CNT_W-1:0] next_count;
	logic [CMP_W-1:0] next_count_ext;
	cell_ctl_t ctl;
	logic [CELL_COUNT-1:0] sel;
	link_t link [CELL_COUNT+1];

	// A decode item waiting for its match holds off the next transfer, since
	// the following bit depends on whether this one cleared the prefix.
	assign item_ready = !pend_q;
	assign accept = item_valid && item_ready;
	assign decode_acc = accept && (item.action == ACT_DECODE);
	assign write_acc = accept && (item.action == ACT_WRITE);

	assign next_bits = {prefix_q[CODE_W-2:0], item.coded_bit};
	assign next_count = count_q + CNT_W'(1);
	assign next_count_ext = CMP_W'(next_count);

	// Only the low bits up to the prefix length take part in a compare.
	always_comb begin
		ctl.write = write_acc;
		ctl.entry = item.symbol[ENTRY_W-1:0];
		ctl.code = item.code;
		ctl.length = item.code_length;
		ctl.probe = decode_acc;
		ctl.bits = next_bits;
		ctl.count = next_count;
		for (int i = 0; i < CODE_W; i++) begin
			ctl.mask[i] = (next_count_ext >= CMP_W'(CODE_W)) ||
			              (CMP_W'(i) < next_count_ext);
		end
	end

	// Writes beyond the symbol count select no cell and are dropped.
	always_comb begin
		for (int k = 0; k < CELL_COUNT; k++) begin
			sel[k] = (item.symbol[SYM_W-1:ENTRY_W] == CELL_ID_W'(k)) &&
			         ({1'b0, item.symbol} < (SYM_W+1)'(SYMBOL_COUNT));
		end
	end

	// The chain runs from the highest cell down to cell 0.
	assign link[CELL_COUNT] = '0;

	for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
		hpd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.sel      (sel[k]),
			.cell_id  (CELL_ID_W'(k)),
			.link_in  (link[k+1]),
			.link_out (link[k])
		);
	end

	assign resolve = pend_q && (!out_valid_q || result_ready);
	assign reached_max = (count_q >= CNT_W'(MAX_CODE_LEN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= '0;
			count_q <= '0;
			pend_q <= 1'b0;
		end else if (decode_acc) begin
			prefix_q <= next_bits;
			count_q <= next_count;
			pend_q <= 1'b1;
		end else if (resolve) begin
			pend_q <= 1'b0;
			if (link[0].hit || reached_max) begin
				prefix_q <= '0;
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resolve && (link[0].hit || reached_max)) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resolve) begin
			if (link[0].hit) begin
				out_q.decoded_symbol <= link[0].symbol;
				out_q.overflow <= 1'b0;
			end else begin
				out_q.decoded_symbol <= '0;
				out_q.overflow <= 1'b1;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_CODE_LEN))
		else $error("prefix count beyond maximum code length");

	a_overflow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.overflow |-> out_q.decoded_symbol == '0)
		else $error("overflow result carries a symbol");

	a_hit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		resolve && link[0].hit |=> count_q == '0 && prefix_q == '0)
		else $error("prefix not cleared after a match");

	a_write_keeps_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		write_acc |=> $stable(count_q) && $stable(prefix_q))
		else $error("write transfer disturbed the prefix");

endmodule

@@ bench/hpd_decode_check.sv @@
// Watches both channels of the decoder, keeps its own copy of the code table
// and the running prefix, and compares every result transfer with the oldest
// result that the accepted items call for.
module hpd_decode_check (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_ready,
	input  hpd_pkg::in_item_t  item,
	input  logic               result_valid,
	input  logic               result_ready,
	input  hpd_pkg::out_item_t result,
	output int                 error_count,
	output int                 awaited_count
);
	import hpd_pkg::*;

	logic [CODE_W-1:0] code_table [SYMBOL_COUNT];
	logic [LEN_W-1:0] length_table [SYMBOL_COUNT];
	logic [CODE_W-1:0] gathered_bits;
	int gathered_count;
	int mismatches;
	out_item_t awaited_results [$];

	// Applies one accepted item to the table or the prefix and queues the
	// result that it causes, if any.
	function automatic void apply_item(input in_item_t it);
		logic [31:0] wide_mask;
		logic [CODE_W-1:0] mask;
		out_item_t res;
		bit hit;
		hit = 1'b0;
		res = '0;
		if (it.action == ACT_WRITE) begin
			if (int'(it.symbol) < SYMBOL_COUNT) begin
				code_table[it.symbol] = it.code;
				length_table[it.symbol] = it.code_length;
			end
		end else begin
			gathered_bits = {gathered_bits[CODE_W-2:0], it.coded_bit};
			gathered_count++;
			wide_mask = (32'd1 << gathered_count) - 32'd1;
			mask = wide_mask[CODE_W-1:0];
			for (int s = SYMBOL_COUNT - 1; s >= 0 && !hit; s--) begin
				if (int'(length_table[s]) == gathered_count &&
				    ((code_table[s] ^ gathered_bits) & mask) == '0) begin
					hit = 1'b1;
					res.decoded_symbol = s[SYM_W-1:0];
					res.overflow = 1'b0;
				end
			end
			if (!hit && gathered_count >= MAX_CODE_LEN) begin
				hit = 1'b1;
				res.decoded_symbol = '0;
				res.overflow = 1'b1;
			end
			if (hit) begin
				awaited_results.push_back(res);
				gathered_bits = '0;
				gathered_count = 0;
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SYMBOL_COUNT; i++) begin
				code_table[i] = '0;
				length_table[i] = '0;
			end
			gathered_bits = '0;
			gathered_count = 0;
			mismatches = 0;
			awaited_results.delete();
			error_count <= 0;
			awaited_count <= 0;
		end else begin
			// A result never belongs to an item taken at the same edge.
			if (result_valid && result_ready) begin
				if (awaited_results.size() == 0) begin
					$error("result transfer with no result awaited: symbol %0d overflow %0d",
					       result.decoded_symbol, result.overflow);
					mismatches++;
				end else begin
					if (result.decoded_symbol !== awaited_results[0].decoded_symbol) begin
						$error("decoded_symbol: expected %0d, actual %0d",
						       awaited_results[0].decoded_symbol, result.decoded_symbol);
						mismatches++;
					end
					if (result.overflow !== awaited_results[0].overflow) begin
						$error("overflow: expected %0d, actual %0d",
						       awaited_results[0].overflow, result.overflow);
						mismatches++;
					end
					void'(awaited_results.pop_front());
				end
			end
			if (item_valid && item_ready) begin
				apply_item(item);
			end
			error_count <= mismatches;
			awaited_count <= awaited_results.size();
		end
	end

endmodule

@@ bench/tb.sv @@
// Top of the decoder bench. It makes the clock, the single reset, the item
// stimulus and the receiver's stalls; hpd_decode_check beside the block does
// all prediction and comparison and reports its error count back here.
module tb;
	import hpd_pkg::*;

	// Far above the slowest correct run: about two thousand items, each with
	// long sender gaps and a heavily stalled receiver, still stay well below.
	localparam int RUN_LIMIT = 500000;
	localparam int PHASE_ITEMS = 670;
	localparam int EPISODE_MAX = 8;

	logic clk;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	in_item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	out_item_t result;

	int fail_total;
	int pending_total;
	int cycle_count = 0;
	int items_sent = 0;

	// Chance in percent that the sender leaves a cycle empty before an item,
	// and that the receiver holds ready low in a cycle.
	int send_gap_pct = 25;
	int recv_stall_pct = 78;

	// Entries that the current episode of random stimulus has loaded. The
	// next episode removes them again, so the table stays sparse and long
	// codes can actually be reached.
	logic [SYM_W-1:0] live_sym [EPISODE_MAX];
	logic [CODE_W-1:0] live_code [EPISODE_MAX];
	logic [LEN_W-1:0] live_len [EPISODE_MAX];
	int live_count = 0;

	huffman_prefix_decoder u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	hpd_decode_check u_decode_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.item          (item),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.result        (result),
		.error_count   (fail_total),
		.awaited_count (pending_total)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The receiver decides anew at every edge whether it takes a result.
	always @(posedge clk) begin
		result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Watchdog: a hang, or a result that never comes, ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// A write item; the coded bit is ignored by the block, so it is random.
	function automatic in_item_t make_write(input logic [SYM_W-1:0] sym,
	                                        input logic [CODE_W-1:0] code,
	                                        input logic [LEN_W-1:0] len);
		in_item_t it;
		it.action = ACT_WRITE;
		it.symbol = sym;
		it.code = code;
		it.code_length = len;
		it.coded_bit = 1'($urandom_range(0, 1));
		return it;
	endfunction

	// A decode item; the table fields are ignored and carry random values.
	function automatic in_item_t make_decode(input logic bit_value);
		in_item_t it;
		it.action = ACT_DECODE;
		it.symbol = SYM_W'($urandom_range(0, 255));
		it.code = CODE_W'($urandom);
		it.code_length = LEN_W'($urandom_range(0, 31));
		it.coded_bit = bit_value;
		return it;
	endfunction

	// Offers one item and returns at the edge where its transfer happens.
	// Valid is only lowered when a gap is actually taken, so it never falls
	// and rises again within one time step.
	task automatic push_item(input in_item_t it);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready) begin
			@(posedge clk);
		end
		items_sent++;
	endtask

	// One episode: remove the previous entries, load a few new ones, then
	// feed mostly whole code words of those entries with some random noise.
	// Noise and code words cut short by other entries produce overflows.
	task automatic run_episode();
		int roll;
		int words;
		int pick;
		for (int i = 0; i < live_count; i++) begin
			push_item(make_write(live_sym[i], CODE_W'($urandom), '0));
		end
		live_count = $urandom_range(1, EPISODE_MAX);
		for (int i = 0; i < live_count; i++) begin
			roll = $urandom_range(0, 99);
			live_sym[i] = SYM_W'($urandom_range(0, 255));
			live_code[i] = CODE_W'($urandom);
			if (roll < 12) begin
				live_len[i] = LEN_W'(MAX_CODE_LEN);
			end else if (roll < 18) begin
				live_len[i] = LEN_W'($urandom_range(MAX_CODE_LEN + 1, 31));
			end else if (roll < 26 && i > 0) begin
				// Same code as the previous entry, so the higher symbol must win.
				live_code[i] = live_code[i-1];
				live_len[i] = live_len[i-1];
			end else if (roll < 65) begin
				live_len[i] = LEN_W'($urandom_range(1, 6));
			end else begin
				live_len[i] = LEN_W'($urandom_range(1, MAX_CODE_LEN - 1));
			end
			push_item(make_write(live_sym[i], live_code[i], live_len[i]));
		end
		words = $urandom_range(2, 10);
		for (int w = 0; w < words; w++) begin
			pick = $urandom_range(0, live_count - 1);
			if ($urandom_range(0, 99) < 15 || live_len[pick] == '0 ||
			    int'(live_len[pick]) > MAX_CODE_LEN) begin
				repeat ($urandom_range(1, 20)) push_item(make_decode(1'($urandom_range(0, 1))));
			end else begin
				for (int b = int'(live_len[pick]) - 1; b >= 0; b--) begin
					push_item(make_decode(live_code[pick][b]));
				end
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Entries with lengths beyond the maximum are stored
		// but must never match.
		push_item(make_write(8'd7, 16'hFFFF, 5'd31));
		push_item(make_write(8'd200, 16'hFFFF, 5'd17));
		push_item(make_write(8'd255, 16'hFFFF, 5'd16));
		// Only the low bit of this code counts, so its code word is a single 0.
		push_item(make_write(8'd0, 16'hFFFE, 5'd1));
		// Same code word as symbol 0; the higher symbol wins.
		push_item(make_write(8'd3, 16'h0000, 5'd1));
		push_item(make_decode(1'b0));
		// Length zero removes the entry, and symbol 0 matches again.
		push_item(make_write(8'd3, 16'h0000, 5'd0));
		push_item(make_decode(1'b0));
		// Fifteen ones and a zero fill the prefix without a match: overflow.
		repeat (15) push_item(make_decode(1'b1));
		push_item(make_decode(1'b0));

		// The first episode clears what the directed part left in the table.
		live_sym[0] = 8'd0;
		live_sym[1] = 8'd255;
		live_sym[2] = 8'd7;
		live_sym[3] = 8'd200;
		live_count = 4;

		// Random part in three idling phases: slow receiver, slow sender,
		// then both at full speed.
		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				send_gap_pct = 78;
				recv_stall_pct = 25;
			end else if (phase == 2) begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
			while (items_sent < 24 + (phase + 1) * PHASE_ITEMS) begin
				run_episode();
			end
		end

		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_total != 0) begin
			@(posedge clk);
		end
		// Leave room for a stray result.
		repeat (8) @(posedge clk);
		if (fail_total == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
